@@ sv/piea_pkg.sv @@
package piea_pkg;

  // Default array geometry
  localparam int DEPTH_DEF         = 16;
  localparam int ELEMENT_WIDTH_DEF = 32;

  // Fixed port field widths
  localparam int REQ_W   = 3;
  localparam int POS_W   = 5;
  localparam int VALUE_W = 32;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;

  // Cells per read reduction group
  localparam int GRP = 16;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT    = 3'd0,
    REQ_PUSH_BACK = 3'd1,
    REQ_ERASE     = 3'd2,
    REQ_POP_BACK  = 3'd3,
    REQ_READ      = 3'd4,
    REQ_READ_LAST = 3'd5,
    REQ_CLEAR     = 3'd6
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Per-cell control for one accepted beat
  typedef struct packed {
    logic load_new;
    logic from_left;
    logic from_right;
    logic rd_sel;
  } cell_ctl_t;

endpackage

@@ sv/positional_insert_erase_array_core.sv @@
// Channel  Direction  Handshake          Payload
// in_      input      in_valid/in_stall  req_type, position, element_value
// out_     output     out_valid/out_stall read_value, status, element_count
//
// One request beat is accepted per cycle while in_stall is low; its result beat
// is registered in the read stage and then in the output register, where it is taken.
// All elements shift at once in the cell row on the accept edge; reads go
// through a registered OR tree over groups of cells, then the output register.
// Reset (synchronous, rst_n low) clears the count and both valid stages;
// element data is not cleared. A stalled output holds; the input stalls only
// when the read stage and the output register are both full and out_stall is high.
module positional_insert_erase_array_core #(
  parameter int DEPTH         = piea_pkg::DEPTH_DEF,
  parameter int ELEMENT_WIDTH = piea_pkg::ELEMENT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [piea_pkg::REQ_W-1:0]    in_req_type,
  input  logic [piea_pkg::POS_W-1:0]    in_position,
  input  logic [piea_pkg::VALUE_W-1:0]  in_element_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [piea_pkg::VALUE_W-1:0]  out_read_value,
  output logic [piea_pkg::STAT_W-1:0]   out_status,
  output logic [piea_pkg::COUNT_W-1:0]  out_element_count
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > piea_pkg::POS_W) ? CW : piea_pkg::POS_W;
  localparam int XW = (ELEMENT_WIDTH > piea_pkg::VALUE_W) ? ELEMENT_WIDTH
                                                          : piea_pkg::VALUE_W;
  localparam int NG = (DEPTH + piea_pkg::GRP - 1) / piea_pkg::GRP;

  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;

  logic                     s1_valid_r;
  logic                     s1_valid_nxt;
  piea_pkg::status_t        s1_status_r;
  logic [CW-1:0]            s1_count_r;
  logic [ELEMENT_WIDTH-1:0] grp_r   [NG];
  logic [ELEMENT_WIDTH-1:0] grp_nxt [NG];

  logic                          out_valid_r;
  logic [piea_pkg::VALUE_W-1:0]  out_read_value_r;
  piea_pkg::status_t             out_status_r;
  logic [piea_pkg::COUNT_W-1:0]  out_element_count_r;

  logic accept;
  logic s1_adv;

  // Decode
  piea_pkg::req_t     req;
  piea_pkg::status_t  status;
  logic [PW-1:0]      pos_x;
  logic [PW-1:0]      cnt_x;
  logic [PW-1:0]      eff_pos;
  logic               do_ins;
  logic               do_era;
  logic               do_rd;
  logic               full;
  logic [XW-1:0]      val_x;
  logic [ELEMENT_WIDTH-1:0] new_val;

  logic [ELEMENT_WIDTH-1:0] cell_data [DEPTH];
  logic [ELEMENT_WIDTH-1:0] cell_rd   [DEPTH];
  piea_pkg::cell_ctl_t      cell_ctl  [DEPTH];

  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign accept   = in_valid && !in_stall;

  assign req     = piea_pkg::req_t'(in_req_type);
  assign pos_x   = PW'(in_position);
  assign cnt_x   = PW'(count_r);
  assign full    = (count_r == CW'(DEPTH));
  assign val_x   = XW'(in_element_value);
  assign new_val = val_x[ELEMENT_WIDTH-1:0];

  always_comb begin
    status    = piea_pkg::ST_DONE;
    count_nxt = count_r;
    eff_pos   = pos_x;
    do_ins    = 1'b0;
    do_era    = 1'b0;
    do_rd     = 1'b0;
    case (req)
      piea_pkg::REQ_INSERT, piea_pkg::REQ_PUSH_BACK: begin
        if (req == piea_pkg::REQ_PUSH_BACK) begin
          eff_pos = cnt_x;
        end
        if (full) begin
          status = piea_pkg::ST_FULL;
        end else if (eff_pos > cnt_x) begin
          status = piea_pkg::ST_RANGE;
        end else begin
          do_ins    = 1'b1;
          count_nxt = count_r + CW'(1);
        end
      end
      piea_pkg::REQ_ERASE, piea_pkg::REQ_POP_BACK: begin
        if (req == piea_pkg::REQ_POP_BACK) begin
          eff_pos = cnt_x - PW'(1);
        end
        if (count_r == '0 || eff_pos >= cnt_x) begin
          status = piea_pkg::ST_RANGE;
        end else begin
          do_era    = 1'b1;
          count_nxt = count_r - CW'(1);
        end
      end
      piea_pkg::REQ_READ, piea_pkg::REQ_READ_LAST: begin
        if (req == piea_pkg::REQ_READ_LAST) begin
          eff_pos = cnt_x - PW'(1);
        end
        if (count_r == '0 || eff_pos >= cnt_x) begin
          status = piea_pkg::ST_RANGE;
        end else begin
          do_rd = 1'b1;
        end
      end
      piea_pkg::REQ_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [PW-1:0] IDX = PW'(i);
    logic [ELEMENT_WIDTH-1:0] left_d;
    logic [ELEMENT_WIDTH-1:0] right_d;

    assign cell_ctl[i].load_new   = do_ins && (IDX == eff_pos);
    assign cell_ctl[i].from_left  = do_ins && (IDX > eff_pos);
    assign cell_ctl[i].from_right = do_era && (IDX >= eff_pos);
    assign cell_ctl[i].rd_sel     = do_rd && (IDX == eff_pos);

    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_data[i+1];
    end

    piea_cell #(
      .ELEMENT_WIDTH(ELEMENT_WIDTH)
    ) u_cell (
      .clk    (clk),
      .en     (accept),
      .ctl    (cell_ctl[i]),
      .left_i (left_d),
      .right_i(right_d),
      .new_i  (new_val),
      .data_o (cell_data[i]),
      .rd_o   (cell_rd[i])
    );
  end

  // First level of the read tree: OR within each group
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_nxt[g] = '0;
      for (int k = 0; k < piea_pkg::GRP; k++) begin
        if (g * piea_pkg::GRP + k < DEPTH) begin
          grp_nxt[g] = grp_nxt[g] | cell_rd[g * piea_pkg::GRP + k];
        end
      end
    end
  end

  // Second level: OR across groups
  logic [ELEMENT_WIDTH-1:0] rd_all;
  logic [XW-1:0]            rd_x;

  always_comb begin
    rd_all = '0;
    for (int g = 0; g < NG; g++) begin
      rd_all = rd_all | grp_r[g];
    end
  end
  assign rd_x = XW'(rd_all);

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (accept) begin
        count_r <= count_nxt;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status_r <= status;
      s1_count_r  <= count_nxt;
      for (int g = 0; g < NG; g++) begin
        grp_r[g] <= grp_nxt[g];
      end
    end
    if (s1_adv) begin
      out_read_value_r    <= rd_x[piea_pkg::VALUE_W-1:0];
      out_status_r        <= s1_status_r;
      out_element_count_r <= piea_pkg::COUNT_W'(s1_count_r);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_read_value    = out_read_value_r;
  assign out_status        = out_status_r;
  assign out_element_count = out_element_count_r;

endmodule

@@ sv/piea_cell.sv @@
module piea_cell #(
  parameter int ELEMENT_WIDTH = piea_pkg::ELEMENT_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     en,
  input  piea_pkg::cell_ctl_t      ctl,
  input  logic [ELEMENT_WIDTH-1:0] left_i,
  input  logic [ELEMENT_WIDTH-1:0] right_i,
  input  logic [ELEMENT_WIDTH-1:0] new_i,
  output logic [ELEMENT_WIDTH-1:0] data_o,
  output logic [ELEMENT_WIDTH-1:0] rd_o
);

  logic [ELEMENT_WIDTH-1:0] data_r;
  logic [ELEMENT_WIDTH-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (en) begin
      if (ctl.load_new) begin
        data_nxt = new_i;
      end else if (ctl.from_left) begin
        data_nxt = left_i;
      end else if (ctl.from_right) begin
        data_nxt = right_i;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;
  // Drive the read bus only when selected
  assign rd_o   = ctl.rd_sel ? data_r : '0;

endmodule

@@ sv/piea_checker.sv @@
module piea_checker #(
  parameter int DEPTH = piea_pkg::DEPTH_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [piea_pkg::REQ_W-1:0]    in_req_type,
  input logic [piea_pkg::POS_W-1:0]    in_position,
  input logic [piea_pkg::VALUE_W-1:0]  in_element_value,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [piea_pkg::VALUE_W-1:0]  out_read_value,
  input logic [piea_pkg::STAT_W-1:0]   out_status,
  input logic [piea_pkg::COUNT_W-1:0]  out_element_count
);

  localparam logic SMALL = (DEPTH < 32);
  localparam logic [piea_pkg::COUNT_W-1:0] DEPTH_C = piea_pkg::COUNT_W'(DEPTH);

  // Count never passes capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!SMALL || out_element_count <= DEPTH_C))
    else $error("element count above capacity");

  // Failed beats carry zero data
  a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != piea_pkg::ST_DONE) |-> out_read_value == '0)
    else $error("nonzero read value on failed request");

  // Full is only reported at capacity
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == piea_pkg::ST_FULL) |->
      (!SMALL || out_element_count == DEPTH_C))
    else $error("full status below capacity");

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_read_value) && $stable(out_status) &&
       $stable(out_element_count)))
    else $error("stalled result beat changed");

  // Stalled request beat holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_stall) |=>
      (in_valid && $stable(in_req_type) && $stable(in_position) &&
       $stable(in_element_value)))
    else $error("stalled request beat changed");

endmodule

bind positional_insert_erase_array_core piea_checker #(
  .DEPTH(DEPTH)
) u_piea_checker (.*);
